[rtl/skippable_priority_queue_core_macros.svh]
// Assertion macros for the priority queue core.
`ifndef SKIPPABLE_PRIORITY_QUEUE_CORE_MACROS_SVH
`define SKIPPABLE_PRIORITY_QUEUE_CORE_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define SPQ_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked at every rising edge outside reset.
`define SPQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/spq_pkg.sv]
`default_nettype none
package spq_pkg;
   localparam int TYPE_W = 16;
   localparam int PRIO_W = 32;
   localparam int SPACING_W = 16;
   localparam logic [SPACING_W-1:0] SPACING_RESET = 16'd10;

   typedef enum logic [3:0] {
      KIND_CLEAR       = 4'd0,
      KIND_INSERT      = 4'd1,
      KIND_INSERT_TOP  = 4'd2,
      KIND_INSERT_BOT  = 4'd3,
      KIND_RESTART     = 4'd4,
      KIND_SKIP        = 4'd5,
      KIND_REMOVE_TOP  = 4'd6,
      KIND_REMOVE_CUR  = 4'd7,
      KIND_READ        = 4'd8
   } kind_type;

   typedef enum logic [2:0] {
      ERR_OK    = 3'd0,
      ERR_FULL  = 3'd1,
      ERR_EMPTY = 3'd2,
      ERR_SKIP  = 3'd3,
      ERR_RANGE = 3'd4
   } err_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;      // capture request fields
      logic execute;   // apply the captured operation
      logic report;    // register the response
   } cmd_type;
endpackage
`default_nettype wire

[rtl/spq_ctrl.sv]
`default_nettype none
module spq_ctrl
   import spq_pkg::*;
(
   input  wire  logic    clock,
   input  wire  logic    reset,
   input  wire  logic    start,
   output logic          busy,
   output cmd_type       cmd,
   output logic          rsp_strobe
);
   typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_REPORT} state_type;

   state_type state_ff, state_in;
   logic      strobe_ff, strobe_in;

   always_comb begin
      state_in  = state_ff;
      strobe_in = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.execute = 1'b1;
            state_in    = ST_REPORT;
         end
         ST_REPORT: begin
            cmd.report = 1'b1;
            strobe_in  = 1'b1;
            state_in   = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = strobe_ff;
endmodule
`default_nettype wire

[rtl/spq_datapath.sv]
`default_nettype none
module spq_datapath
   import spq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 32
) (
   input  wire  logic                  clock,
   input  wire  logic                  reset,
   input  wire  cmd_type               cmd,
   input  wire  logic [3:0]            req_kind,
   input  wire  logic [TYPE_W-1:0]     req_unit_type,
   input  wire  logic signed [PRIO_W-1:0] req_new_priority,
   input  wire  logic                  req_is_blocking,
   input  wire  logic [4:0]            req_read_index,
   input  wire  logic                  csr_write,
   input  wire  logic [SPACING_W-1:0]  csr_data,
   output logic [TYPE_W-1:0]           rsp_item_type,
   output logic signed [PRIO_W-1:0]    rsp_item_priority,
   output logic                        rsp_item_blocking,
   output logic                        rsp_item_valid,
   output logic                        rsp_skip_allowed,
   output logic [5:0]                  rsp_entry_count,
   output logic [2:0]                  rsp_error_code
);
   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);
   localparam logic signed [PRIO_W:0] PMAX = 33'sd2147483647;
   localparam logic signed [PRIO_W:0] PMIN = -33'sd2147483648;

   // Shifting cell array, bottom at index 0.
   logic [TYPE_W-1:0]        type_ff [QUEUE_DEPTH];
   logic signed [PRIO_W-1:0] prio_ff [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0]   blk_ff;

   logic [CNT_W-1:0]         fill_ff, fill_in;
   logic [CNT_W-1:0]         skip_ff, skip_in;
   logic signed [PRIO_W-1:0] top_ff, top_in, bot_ff, bot_in;
   logic [SPACING_W-1:0]     spacing_ff;
   kind_type                 kind_ff;
   logic [TYPE_W-1:0]        utype_ff;
   logic signed [PRIO_W-1:0] nprio_ff;
   logic                     nblk_ff;
   logic [4:0]               ridx_ff;
   err_type                  err_ff, err_in;

   logic signed [PRIO_W:0]   rel_sum;
   logic signed [PRIO_W-1:0] ins_prio, ins_top, ins_bot;
   logic [QUEUE_DEPTH-1:0]   le_vec;
   logic                     do_ins, do_rem, to_bottom;
   logic [CNT_W-1:0]         rem_pos;
   logic                     cur_blk;

   always_ff @(posedge clock) begin
      if (reset) spacing_ff <= SPACING_RESET;
      else if (csr_write) spacing_ff <= csr_data;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff  <= kind_type'(req_kind);
         utype_ff <= req_unit_type;
         nprio_ff <= req_new_priority;
         nblk_ff  <= req_is_blocking;
         ridx_ff  <= req_read_index;
      end
   end

   always_comb begin
      rel_sum = '0;
      unique case (kind_ff)
         KIND_INSERT_TOP: rel_sum = {top_ff[PRIO_W-1], top_ff} + $signed({17'd0, spacing_ff});
         KIND_INSERT_BOT: rel_sum = {bot_ff[PRIO_W-1], bot_ff} - $signed({17'd0, spacing_ff});
         default:         rel_sum = '0;
      endcase
      if (kind_ff == KIND_INSERT) ins_prio = nprio_ff;
      else if (rel_sum > PMAX) ins_prio = PMAX[PRIO_W-1:0];
      else if (rel_sum < PMIN) ins_prio = PMIN[PRIO_W-1:0];
      else ins_prio = rel_sum[PRIO_W-1:0];
   end

   always_comb begin
      ins_top = (fill_ff == '0) ? ins_prio : top_ff;
      ins_bot = (fill_ff == '0) ? ins_prio : bot_ff;
      to_bottom = !(ins_prio > ins_bot);
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         le_vec[i] = (CNT_W'(i) < fill_ff) && (prio_ff[i] <= ins_prio) && !to_bottom;
      end
   end

   always_comb begin
      fill_in = fill_ff;
      skip_in = skip_ff;
      top_in  = top_ff;
      bot_in  = bot_ff;
      err_in  = ERR_OK;
      do_ins  = 1'b0;
      do_rem  = 1'b0;
      rem_pos = fill_ff - 1'b1;
      cur_blk = blk_ff[IDX_W'(fill_ff - 1'b1 - skip_ff)];
      case (kind_ff)
         KIND_CLEAR: begin
            fill_in = '0;
            top_in  = '0;
            bot_in  = '0;
         end
         KIND_INSERT, KIND_INSERT_TOP, KIND_INSERT_BOT: begin
            if (fill_ff >= DEPTH_C) err_in = ERR_FULL;
            else begin
               do_ins  = 1'b1;
               fill_in = fill_ff + 1'b1;
               top_in  = (ins_prio > ins_top) ? ins_prio : ins_top;
               bot_in  = (ins_prio < ins_bot) ? ins_prio : ins_bot;
            end
         end
         KIND_RESTART: begin
            skip_in = '0;
            if (fill_ff == '0) err_in = ERR_EMPTY;
         end
         KIND_SKIP: begin
            if ((fill_ff > skip_ff + 1'b1) && !cur_blk) skip_in = skip_ff + 1'b1;
            else err_in = ERR_SKIP;
         end
         KIND_REMOVE_TOP, KIND_REMOVE_CUR: begin
            if (fill_ff == '0) err_in = ERR_EMPTY;
            else if (kind_ff == KIND_REMOVE_CUR && skip_ff >= fill_ff) err_in = ERR_RANGE;
            else begin
               do_rem  = 1'b1;
               if (kind_ff == KIND_REMOVE_CUR) rem_pos = fill_ff - 1'b1 - skip_ff;
               fill_in = fill_ff - 1'b1;
               if (fill_ff == CNT_W'(1)) begin
                  top_in = '0;
                  bot_in = '0;
               end else if (rem_pos == fill_ff - 1'b1) top_in = prio_ff[IDX_W'(fill_ff - 2'd2)];
               else top_in = prio_ff[IDX_W'(fill_ff - 1'b1)];
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (do_ins) begin
               if (le_vec[i]) begin
               end else if (i == 0 || le_vec[i-1]) begin
                  type_ff[i] <= utype_ff;
                  prio_ff[i] <= ins_prio;
                  blk_ff[i]  <= nblk_ff;
               end else begin
                  type_ff[i] <= type_ff[i-1];
                  prio_ff[i] <= prio_ff[i-1];
                  blk_ff[i]  <= blk_ff[i-1];
               end
            end else if (do_rem && CNT_W'(i) >= rem_pos && i + 1 < QUEUE_DEPTH) begin
               type_ff[i] <= type_ff[i+1];
               prio_ff[i] <= prio_ff[i+1];
               blk_ff[i]  <= blk_ff[i+1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         skip_ff <= '0;
         top_ff  <= '0;
         bot_ff  <= '0;
         err_ff  <= ERR_OK;
      end else if (cmd.execute) begin
         fill_ff <= fill_in;
         skip_ff <= skip_in;
         top_ff  <= top_in;
         bot_ff  <= bot_in;
         err_ff  <= err_in;
      end
   end

   logic             have;
   logic [CNT_W-1:0] pos;
   always_comb begin
      have = 1'b0;
      pos  = fill_ff - 1'b1 - skip_ff;
      if (kind_ff == KIND_READ) begin
         if (32'(ridx_ff) < 32'(fill_ff)) begin
            have = 1'b1;
            pos  = CNT_W'(ridx_ff);
         end
      end else if (skip_ff < fill_ff) have = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (cmd.report) begin
         rsp_item_type     <= have ? type_ff[IDX_W'(pos)] : '0;
         rsp_item_priority <= have ? prio_ff[IDX_W'(pos)] : '0;
         rsp_item_blocking <= have ? blk_ff[IDX_W'(pos)] : 1'b0;
         rsp_item_valid    <= have;
         rsp_skip_allowed  <= (fill_ff > skip_ff + 1'b1) && !cur_blk;
         rsp_entry_count   <= 6'(fill_ff);
         rsp_error_code    <= (kind_ff == KIND_READ && !have) ? ERR_RANGE : err_ff;
      end
   end
endmodule
`default_nettype wire

[rtl/skippable_priority_queue_core.sv]
// A request taken by start passes the execute and report states; busy is high in both.
// The cell array shifts in the execute state; the reported entry and rsp_strobe are
// registered from the report state. A new request is taken only when idle.
// The receiver cannot stall; every result is flagged by rsp_strobe for one cycle.
// Synchronous active-high reset empties the queue and sets spacing to 10.
`default_nettype none
`include "skippable_priority_queue_core_macros.svh"
module skippable_priority_queue_core
   import spq_pkg::*;
#(
   parameter int QUEUE_DEPTH = 32
) (
   input  wire  logic                    clock,
   input  wire  logic                    reset,
   input  wire  logic                    start,
   output logic                          busy,
   input  wire  logic [3:0]              req_kind,
   input  wire  logic [15:0]             req_unit_type,
   input  wire  logic signed [31:0]      req_new_priority,
   input  wire  logic                    req_is_blocking,
   input  wire  logic [4:0]              req_read_index,
   input  wire  logic                    csr_write,
   input  wire  logic [15:0]             csr_data,
   output logic                          rsp_strobe,
   output logic [15:0]                   rsp_item_type,
   output logic signed [31:0]            rsp_item_priority,
   output logic                          rsp_item_blocking,
   output logic                          rsp_item_valid,
   output logic                          rsp_skip_allowed,
   output logic [5:0]                    rsp_entry_count,
   output logic [2:0]                    rsp_error_code
);
   cmd_type cmd;
   logic    count_ok;

   spq_ctrl u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .cmd(cmd), .rsp_strobe(rsp_strobe)
   );

   spq_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd),
      .req_kind(req_kind), .req_unit_type(req_unit_type),
      .req_new_priority(req_new_priority), .req_is_blocking(req_is_blocking),
      .req_read_index(req_read_index), .csr_write(csr_write), .csr_data(csr_data),
      .rsp_item_type(rsp_item_type), .rsp_item_priority(rsp_item_priority),
      .rsp_item_blocking(rsp_item_blocking), .rsp_item_valid(rsp_item_valid),
      .rsp_skip_allowed(rsp_skip_allowed), .rsp_entry_count(rsp_entry_count),
      .rsp_error_code(rsp_error_code)
   );

   assign count_ok = (32'(rsp_entry_count) <= QUEUE_DEPTH);

   `SPQ_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy, "busy not raised")
   `SPQ_ASSERT_IMP(a_strobe_busy, clock, reset, rsp_strobe, !busy, "strobe while busy")
   `SPQ_ASSERT_IMP(a_count_range, clock, reset, rsp_strobe, count_ok, "count too big")
endmodule
`default_nettype wire

[bench/skippable_priority_queue_core_tb.sv]
`timescale 1ns / 1ps
module skippable_priority_queue_core_tb;
   import spq_pkg::*;

   localparam int DEPTH = 32;

   typedef struct {
      logic [3:0]         kind;
      logic [15:0]        utype;
      logic signed [31:0] prio;
      logic               blk;
      logic [4:0]         ridx;
   } op_type;

   typedef struct {
      logic [15:0]        item_type;
      logic signed [31:0] item_priority;
      logic               item_blocking;
      logic               item_valid;
      logic               skip_allowed;
      logic [5:0]         entry_count;
      logic [2:0]         error_code;
   } entry_report_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [3:0]         req_kind;
   logic [15:0]        req_unit_type;
   logic signed [31:0] req_new_priority;
   logic               req_is_blocking;
   logic [4:0]         req_read_index;
   logic               csr_write;
   logic [15:0]        csr_data;
   logic               rsp_strobe;
   logic [15:0]        rsp_item_type;
   logic signed [31:0] rsp_item_priority;
   logic               rsp_item_blocking;
   logic               rsp_item_valid;
   logic               rsp_skip_allowed;
   logic [5:0]         rsp_entry_count;
   logic [2:0]         rsp_error_code;

   skippable_priority_queue_core #(.QUEUE_DEPTH(DEPTH)) u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_unit_type(req_unit_type),
      .req_new_priority(req_new_priority), .req_is_blocking(req_is_blocking),
      .req_read_index(req_read_index), .csr_write(csr_write), .csr_data(csr_data),
      .rsp_strobe(rsp_strobe), .rsp_item_type(rsp_item_type),
      .rsp_item_priority(rsp_item_priority), .rsp_item_blocking(rsp_item_blocking),
      .rsp_item_valid(rsp_item_valid), .rsp_skip_allowed(rsp_skip_allowed),
      .rsp_entry_count(rsp_entry_count), .rsp_error_code(rsp_error_code)
   );

   // queue shadow
   logic [15:0]      sh_type [DEPTH];
   longint           sh_prio [DEPTH];
   logic             sh_blk  [DEPTH];
   int               sh_fill;
   int               sh_skip;
   longint           sh_top;
   longint           sh_bot;
   longint           sh_spacing;
   entry_report_type pending_reports[$];
   int               fails;

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   function automatic bit can_skip();
      if (sh_fill <= 1 + sh_skip) return 0;
      return !sh_blk[sh_fill - 1 - sh_skip];
   endfunction

   function automatic logic [2:0] place_entry(logic [15:0] ut, longint p, logic b);
      int pos;
      pos = 0;
      if (sh_fill >= DEPTH) return ERR_FULL;
      if (sh_fill == 0) begin
         sh_top = p;
         sh_bot = p;
      end
      if (p > sh_bot) begin
         while (pos < sh_fill && sh_prio[pos] <= p) pos++;
      end
      for (int i = sh_fill; i > pos; i--) begin
         sh_type[i] = sh_type[i-1];
         sh_prio[i] = sh_prio[i-1];
         sh_blk[i]  = sh_blk[i-1];
      end
      sh_type[pos] = ut;
      sh_prio[pos] = p;
      sh_blk[pos]  = b;
      sh_fill++;
      if (p > sh_top) sh_top = p;
      if (p < sh_bot) sh_bot = p;
      return ERR_OK;
   endfunction

   function automatic void drop_entry(int pos);
      for (int i = pos; i + 1 < sh_fill; i++) begin
         sh_type[i] = sh_type[i+1];
         sh_prio[i] = sh_prio[i+1];
         sh_blk[i]  = sh_blk[i+1];
      end
      sh_fill--;
      if (sh_fill == 0) begin
         sh_top = 0;
         sh_bot = 0;
      end else begin
         sh_top = sh_prio[sh_fill-1];
      end
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic entry_report_type apply_op(op_type op);
      entry_report_type r;
      logic [2:0] err;
      bit have;
      int pos;
      err = ERR_OK;
      have = 0;
      pos = 0;
      case (op.kind)
         KIND_CLEAR: begin
            sh_fill = 0;
            sh_top = 0;
            sh_bot = 0;
         end
         KIND_INSERT: err = place_entry(op.utype, longint'(op.prio), op.blk);
         KIND_INSERT_TOP: err = place_entry(op.utype, clamp32(sh_top + sh_spacing), op.blk);
         KIND_INSERT_BOT: err = place_entry(op.utype, clamp32(sh_bot - sh_spacing), op.blk);
         KIND_RESTART: begin
            sh_skip = 0;
            if (sh_fill == 0) err = ERR_EMPTY;
         end
         KIND_SKIP: begin
            if (can_skip()) sh_skip++;
            else err = ERR_SKIP;
         end
         KIND_REMOVE_TOP: begin
            if (sh_fill == 0) err = ERR_EMPTY;
            else drop_entry(sh_fill - 1);
         end
         KIND_REMOVE_CUR: begin
            if (sh_fill == 0) err = ERR_EMPTY;
            else if (sh_skip >= sh_fill) err = ERR_RANGE;
            else drop_entry(sh_fill - 1 - sh_skip);
         end
         default: ;
      endcase
      if (op.kind == KIND_READ) begin
         if (op.ridx < sh_fill) begin
            have = 1;
            pos = op.ridx;
         end else begin
            err = ERR_RANGE;
         end
      end else if (sh_skip < sh_fill) begin
         have = 1;
         pos = sh_fill - 1 - sh_skip;
      end
      r.item_type     = have ? sh_type[pos] : '0;
      r.item_priority = have ? 32'(sh_prio[pos]) : '0;
      r.item_blocking = have ? sh_blk[pos] : 1'b0;
      r.item_valid    = have;
      r.skip_allowed  = can_skip();
      r.entry_count   = 6'(sh_fill);
      r.error_code    = err;
      return r;
   endfunction

   always @(negedge clock) begin : check_rsp
      entry_report_type e;
      if (!reset && rsp_strobe) begin
         if (pending_reports.size() == 0) begin
            $error("unexpected result item");
            fails++;
         end else begin
            e = pending_reports.pop_front();
            if (rsp_item_type !== e.item_type) begin
               $error("item_type exp %0h got %0h", e.item_type, rsp_item_type);
               fails++;
            end
            if (rsp_item_priority !== e.item_priority) begin
               $error("item_priority exp %0d got %0d", e.item_priority, rsp_item_priority);
               fails++;
            end
            if (rsp_item_blocking !== e.item_blocking) begin
               $error("item_blocking exp %0b got %0b", e.item_blocking, rsp_item_blocking);
               fails++;
            end
            if (rsp_item_valid !== e.item_valid) begin
               $error("item_valid exp %0b got %0b", e.item_valid, rsp_item_valid);
               fails++;
            end
            if (rsp_skip_allowed !== e.skip_allowed) begin
               $error("skip_allowed exp %0b got %0b", e.skip_allowed, rsp_skip_allowed);
               fails++;
            end
            if (rsp_entry_count !== e.entry_count) begin
               $error("entry_count exp %0d got %0d", e.entry_count, rsp_entry_count);
               fails++;
            end
            if (rsp_error_code !== e.error_code) begin
               $error("error_code exp %0d got %0d", e.error_code, rsp_error_code);
               fails++;
            end
         end
      end
   end

   // called at a rising edge; returns at the edge that took the item
   task automatic send_op(op_type op, int idle_pct);
      int gap;
      entry_report_type exp_r;
      gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 8) : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start            <= 1'b1;
      req_kind         <= op.kind;
      req_unit_type    <= op.utype;
      req_new_priority <= op.prio;
      req_is_blocking  <= op.blk;
      req_read_index   <= op.ridx;
      forever begin
         @(negedge clock);
         if (!busy) break;
         @(posedge clock);
      end
      @(posedge clock);
      exp_r = apply_op(op);
      pending_reports.insert(pending_reports.size(), exp_r);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_spacing(logic [15:0] v);
      csr_write <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      csr_write <= 1'b0;
      sh_spacing = v;
   endtask

   function automatic op_type mk(logic [3:0] k, logic [15:0] ut, logic signed [31:0] p,
                                 logic b, logic [4:0] ri);
      op_type o;
      o.kind = k;
      o.utype = ut;
      o.prio = p;
      o.blk = b;
      o.ridx = ri;
      return o;
   endfunction

   function automatic op_type rand_op(int ins_pct);
      op_type o;
      int r;
      o = mk(KIND_READ, 16'($urandom), 32'($urandom), 1'($urandom), 5'($urandom));
      r = $urandom_range(99);
      if (r < ins_pct) begin
         case ($urandom_range(2))
            0: o.kind = KIND_INSERT;
            1: o.kind = KIND_INSERT_TOP;
            default: o.kind = KIND_INSERT_BOT;
         endcase
      end else begin
         case ($urandom_range(19))
            0: o.kind = KIND_CLEAR;
            1, 2: o.kind = KIND_RESTART;
            3, 4, 5, 6: o.kind = KIND_SKIP;
            7, 8, 9: o.kind = KIND_REMOVE_TOP;
            10, 11, 12: o.kind = KIND_REMOVE_CUR;
            13, 14, 15, 16: o.kind = KIND_READ;
            17: o.kind = 4'($urandom_range(9, 15));
            default: o.kind = KIND_INSERT;
         endcase
      end
      case ($urandom_range(5))
         0, 1, 2: o.prio = 32'($signed($urandom_range(16)) - 8);
         3: o.prio = $urandom_range(1) ? 32'h7fff_fff0 + 32'($urandom_range(15))
                                       : 32'h8000_0000 + 32'($urandom_range(15));
         default: o.prio = 32'($urandom);
      endcase
      o.blk = ($urandom_range(3) == 0);
      return o;
   endfunction

   task automatic test_reset_state();
      send_op(mk(KIND_READ, 16'h0, 32'sd0, 1'b0, 5'd0), 0);
      send_op(mk(KIND_SKIP, 16'h0, 32'sd0, 1'b0, 5'd0), 0);
      send_op(mk(KIND_RESTART, 16'h0, 32'sd0, 1'b0, 5'd0), 0);
      send_op(mk(KIND_REMOVE_TOP, 16'h0, 32'sd0, 1'b0, 5'd0), 0);
      send_op(mk(KIND_REMOVE_CUR, 16'h0, 32'sd0, 1'b0, 5'd0), 0);
      drain();
   endtask

   task automatic test_corner_cases();
      write_spacing(16'hffff);
      send_op(mk(KIND_INSERT, 16'hffff, 32'sh7fff_fffe, 1'b0, 5'd0), 0);
      send_op(mk(KIND_INSERT_TOP, 16'h1234, 32'sd0, 1'b1, 5'd0), 0);
      send_op(mk(KIND_INSERT, 16'h0001, 32'sh8000_0005, 1'b0, 5'd0), 0);
      send_op(mk(KIND_INSERT_BOT, 16'h0002, 32'sd0, 1'b0, 5'd0), 0);
      send_op(mk(KIND_INSERT, 16'h0003, 32'sd0, 1'b0, 5'd0), 0);
      send_op(mk(KIND_INSERT, 16'h0004, 32'sd0, 1'b1, 5'd0), 0);
      // blocking top refuses a skip
      send_op(mk(KIND_SKIP, 16'h0, 32'sd0, 1'b0, 5'd0), 0);
      send_op(mk(KIND_REMOVE_TOP, 16'h0, 32'sd0, 1'b0, 5'd0), 0);
      send_op(mk(KIND_SKIP, 16'h0, 32'sd0, 1'b0, 5'd0), 0);
      send_op(mk(KIND_REMOVE_CUR, 16'h0, 32'sd0, 1'b0, 5'd0), 0);
      send_op(mk(KIND_READ, 16'h0, 32'sd0, 1'b0, 5'd31), 0);
      send_op(mk(KIND_READ, 16'h0, 32'sd0, 1'b0, 5'd1), 0);
      send_op(mk(4'd15, 16'h0, 32'sd0, 1'b0, 5'd0), 0);
      send_op(mk(KIND_RESTART, 16'h0, 32'sd0, 1'b0, 5'd0), 0);
      send_op(mk(KIND_CLEAR, 16'h0, 32'sd0, 1'b0, 5'd0), 0);
      // insert two entries, then remove the top and the current entry
      send_op(mk(KIND_INSERT, 16'h00a0, 32'sd5, 1'b0, 5'd0), 0);
      send_op(mk(KIND_INSERT, 16'h00a1, 32'sd6, 1'b0, 5'd0), 0);
      send_op(mk(KIND_REMOVE_TOP, 16'h0, 32'sd0, 1'b0, 5'd0), 0);
      send_op(mk(KIND_REMOVE_CUR, 16'h0, 32'sd0, 1'b0, 5'd0), 0);
      send_op(mk(KIND_CLEAR, 16'h0, 32'sd0, 1'b0, 5'd0), 0);
      drain();
      write_spacing(16'h0000);
      send_op(mk(KIND_INSERT_BOT, 16'h0, 32'sd0, 1'b0, 5'd0), 0);
      send_op(mk(KIND_INSERT_BOT, 16'h0, 32'sd0, 1'b1, 5'd0), 0);
      send_op(mk(KIND_INSERT_TOP, 16'h0, 32'sd0, 1'b0, 5'd0), 0);
      drain();
   endtask

   task automatic test_random_traffic();
      int idle[4] = '{0, 58, 0, 34};
      logic [15:0] spc[4] = '{16'd1, 16'hffff, 16'd10, 16'h0};
      for (int ph = 0; ph < 4; ph++) begin
         write_spacing(ph == 3 ? 16'($urandom) : spc[ph]);
         for (int n = 0; n < 175; n++)
            send_op(rand_op((n / 44) % 2 == 0 ? 75 : 25), idle[ph]);
         drain();
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_kind = '0;
      req_unit_type = '0;
      req_new_priority = '0;
      req_is_blocking = 1'b0;
      req_read_index = '0;
      csr_write = 1'b0;
      csr_data = '0;
      fails = 0;
      sh_fill = 0;
      sh_skip = 0;
      sh_top = 0;
      sh_bot = 0;
      sh_spacing = SPACING_RESET;
      for (int i = 0; i < DEPTH; i++) begin
         sh_type[i] = '0;
         sh_prio[i] = 0;
         sh_blk[i] = 1'b0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_corner_cases();
      test_random_traffic();
      if (fails == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
